// ===== rtl/core/distance_hold_pid_controller_unit_defines.svh =====
// assertion macros for the distance hold controller
`ifndef DISTANCE_HOLD_PID_CONTROLLER_UNIT_DEFINES_SVH
`define DISTANCE_HOLD_PID_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication
`define DHPC_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("dhpc same-cycle check failed");

// next-cycle implication
`define DHPC_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("dhpc next-cycle check failed");

`endif

// ===== rtl/core/dhpc_pkg.sv =====
`timescale 1ns / 1ps

package dhpc_pkg;

  localparam int DIST_BITS_DEF      = 13;
  localparam int GAIN_FRAC_BITS_DEF = 24;

  localparam int GAIN_W  = 32;
  localparam int SUM_W   = 32;
  localparam int KEEP_W  = 9;
  localparam int LIMIT_W = 8;
  localparam int DRIVE_W = 9;
  localparam int OUT_W   = 16;
  localparam int ACC_W   = 74;
  localparam int CNT_W   = $clog2(GAIN_W);
  localparam int CFG_IDX_W = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_GAIN_PROP   = 3'd0;
  localparam cfg_index_t REG_GAIN_INTEG  = 3'd1;
  localparam cfg_index_t REG_GAIN_DERIV  = 3'd2;
  localparam cfg_index_t REG_FILTER_KEEP = 3'd3;
  localparam cfg_index_t REG_TARGET_MM   = 3'd4;
  localparam cfg_index_t REG_STOP_MM     = 3'd5;
  localparam cfg_index_t REG_DRIVE_LIMIT = 3'd6;

  localparam logic [GAIN_W-1:0]  GAIN_PROP_RST   = 32'd69357;
  localparam logic [GAIN_W-1:0]  GAIN_INTEG_RST  = 32'd1627;
  localparam logic [GAIN_W-1:0]  GAIN_DERIV_RST  = 32'd1137059;
  localparam logic [KEEP_W-1:0]  FILTER_KEEP_RST = 9'd179;
  localparam logic [KEEP_W-1:0]  KEEP_FULL       = 9'd256;
  localparam int                 TARGET_MM_RST   = 150;
  localparam int                 STOP_MM_RST     = 30;
  localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = 8'd255;

endpackage

// ===== rtl/core/distance_hold_pid_controller_unit.sv =====
`timescale 1ns / 1ps
`include "distance_hold_pid_controller_unit_defines.svh"

// Distance hold PID controller, one beat in and one beat out per control tick.
// Slave stream: s_tdata carries distance_mm in the low DIST_BITS bits and the
// running flag just above it. Master stream: m_tdata carries drive (signed),
// emergency, saturated and paused from bit 0 up. Gains, filter share, target,
// stop distance and drive limit are written on the cfg channel, which is always
// ready; write it only while no tick is in flight.
// A paused or emergency tick skips the multiplier and goes straight to the
// result state. A controlled tick runs the filter and the three gain products
// through one shift-add multiplier that retires one multiplier bit per cycle,
// over the 9 bits of the filter share and the 32 bits of each gain. s_tready is
// high only between ticks, so a new input beat is not taken before the last
// tick is through. The result passes from result registers to an output
// register; if the receiver stalls, the finished tick waits in the result
// registers and the next input beat is taken only after it is delivered to the
// output register. Synchronous reset restores the register defaults and clears
// last error, error sum and filtered difference.
module distance_hold_pid_controller_unit #(
  parameter int DIST_BITS      = dhpc_pkg::DIST_BITS_DEF,
  parameter int GAIN_FRAC_BITS = dhpc_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // distance_mm, running
  input  logic [((DIST_BITS + 8) / 8) * 8 - 1:0] s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // drive, emergency, saturated, paused
  output logic [dhpc_pkg::OUT_W-1:0]        m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  dhpc_pkg::cfg_index_t              cfg_index,
  input  logic [dhpc_pkg::GAIN_W-1:0]       cfg_data
);

  localparam int ERR_W   = DIST_BITS + 1;
  localparam int RAW_W   = DIST_BITS + 2;
  localparam int SD_W    = RAW_W + 8;
  localparam int SHIFT   = GAIN_FRAC_BITS + 8;
  localparam int ACC_W   = dhpc_pkg::ACC_W;
  localparam int GAIN_W  = dhpc_pkg::GAIN_W;
  localparam int SUM_W   = dhpc_pkg::SUM_W;
  localparam int KEEP_W  = dhpc_pkg::KEEP_W;
  localparam int DRIVE_W = dhpc_pkg::DRIVE_W;
  localparam int CNT_W   = dhpc_pkg::CNT_W;

  localparam logic [CNT_W-1:0] KEEP_LAST = CNT_W'(KEEP_W - 1);
  localparam logic [CNT_W-1:0] GAIN_LAST = CNT_W'(GAIN_W - 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FKEEP = 4'd1;
  localparam logic [3:0] ST_FNEW  = 4'd2;
  localparam logic [3:0] ST_FDIV  = 4'd3;
  localparam logic [3:0] ST_PROP  = 4'd4;
  localparam logic [3:0] ST_INTEG = 4'd5;
  localparam logic [3:0] ST_DERIV = 4'd6;
  localparam logic [3:0] ST_FIN   = 4'd7;
  localparam logic [3:0] ST_RES   = 4'd8;

  logic [3:0] state;

  logic [GAIN_W-1:0]           gain_prop;
  logic [GAIN_W-1:0]           gain_integ;
  logic [GAIN_W-1:0]           gain_deriv;
  logic [KEEP_W-1:0]           filter_keep;
  logic [DIST_BITS-1:0]        target_mm;
  logic [DIST_BITS-1:0]        stop_mm;
  logic [dhpc_pkg::LIMIT_W-1:0] drive_limit;

  logic [ERR_W-1:0] last_error;
  logic [SUM_W-1:0] error_sum;
  logic [SD_W-1:0]  smoothed_diff;

  logic [ERR_W-1:0]  err_q;
  logic [RAW_W-1:0]  raw_q;
  logic [SUM_W-1:0]  prev_sum;
  logic [KEEP_W-1:0] keep_q;

  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  mcand;
  logic [GAIN_W-1:0] mplier;
  logic [CNT_W-1:0]  cnt;

  logic [DRIVE_W-1:0] res_drive;
  logic               res_emerg;
  logic               res_sat;
  logic               res_paused;

  logic [DRIVE_W-1:0] out_drive;
  logic               out_emerg;
  logic               out_sat;
  logic               out_paused;

  logic [DIST_BITS-1:0] dist_mm;
  logic                 run;
  logic [ERR_W-1:0]     err_in;
  logic [RAW_W-1:0]     raw_in;
  logic [SUM_W:0]       sum_ext;
  logic [SUM_W-1:0]     sum_sat;
  logic [KEEP_W-1:0]    keep_eff;
  logic                 in_mul;
  logic                 step_last;
  logic [ACC_W-1:0]     acc_add;
  logic [ACC_W-1:0]     f_adj;
  logic [SD_W-1:0]      sd_new;
  logic                 neg;
  logic [ACC_W-1:0]     mag;
  logic [ACC_W-1:0]     lim;
  logic                 over;
  logic [ACC_W-1:0]     quo;
  logic [DRIVE_W-1:0]   qd;
  logic [DRIVE_W-1:0]   lim_d;
  logic [DRIVE_W-1:0]   drive_fin;
  logic [2:0]           out_flags;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = {{(dhpc_pkg::OUT_W - DRIVE_W - 3){1'b0}},
                      out_paused, out_sat, out_emerg, out_drive};

  assign dist_mm = s_tdata[DIST_BITS-1:0];
  assign run     = s_tdata[DIST_BITS];

  always_comb begin
    err_in  = {1'b0, dist_mm} - {1'b0, target_mm};
    raw_in  = {err_in[ERR_W-1], err_in} - {last_error[ERR_W-1], last_error};
    sum_ext = {error_sum[SUM_W-1], error_sum}
              + {{(SUM_W + 1 - ERR_W){err_in[ERR_W-1]}}, err_in};
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                               : {1'b0, {(SUM_W - 1){1'b1}}};
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
    keep_eff = (filter_keep > dhpc_pkg::KEEP_FULL) ? dhpc_pkg::KEEP_FULL : filter_keep;
  end

  assign in_mul    = state inside {ST_FKEEP, ST_FNEW, ST_PROP, ST_INTEG, ST_DERIV};
  assign step_last = (cnt == ((state == ST_FKEEP || state == ST_FNEW) ? KEEP_LAST
                                                                      : GAIN_LAST));
  assign acc_add   = mplier[0] ? acc + mcand : acc;

  // filter divide by 256, truncating toward zero
  always_comb begin
    f_adj  = acc + (acc[ACC_W-1] ? ACC_W'(255) : '0);
    sd_new = f_adj[SD_W+7:8];
  end

  // clamp and truncate
  always_comb begin
    neg       = acc[ACC_W-1];
    mag       = neg ? (~acc + ACC_W'(1)) : acc;
    lim       = ACC_W'(drive_limit) << SHIFT;
    over      = (mag > lim);
    quo       = mag >> SHIFT;
    qd        = quo[DRIVE_W-1:0];
    lim_d     = {1'b0, drive_limit};
    if (over) begin
      drive_fin = neg ? (~lim_d + DRIVE_W'(1)) : lim_d;
    end else begin
      drive_fin = neg ? (~qd + DRIVE_W'(1)) : qd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_tvalid      <= 1'b0;
      gain_prop     <= dhpc_pkg::GAIN_PROP_RST;
      gain_integ    <= dhpc_pkg::GAIN_INTEG_RST;
      gain_deriv    <= dhpc_pkg::GAIN_DERIV_RST;
      filter_keep   <= dhpc_pkg::FILTER_KEEP_RST;
      target_mm     <= DIST_BITS'(dhpc_pkg::TARGET_MM_RST);
      stop_mm       <= DIST_BITS'(dhpc_pkg::STOP_MM_RST);
      drive_limit   <= dhpc_pkg::DRIVE_LIMIT_RST;
      last_error    <= '0;
      error_sum     <= '0;
      smoothed_diff <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          dhpc_pkg::REG_GAIN_PROP:   gain_prop   <= cfg_data;
          dhpc_pkg::REG_GAIN_INTEG:  gain_integ  <= cfg_data;
          dhpc_pkg::REG_GAIN_DERIV:  gain_deriv  <= cfg_data;
          dhpc_pkg::REG_FILTER_KEEP: filter_keep <= cfg_data[KEEP_W-1:0];
          dhpc_pkg::REG_TARGET_MM:   target_mm   <= cfg_data[DIST_BITS-1:0];
          dhpc_pkg::REG_STOP_MM:     stop_mm     <= cfg_data[DIST_BITS-1:0];
          dhpc_pkg::REG_DRIVE_LIMIT: drive_limit <= cfg_data[dhpc_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready && state != ST_RES) begin
        m_tvalid <= 1'b0;
      end

      // shared shift-add step
      if (in_mul) begin
        acc <= acc_add;
        if (!step_last) begin
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt + CNT_W'(1);
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (!run) begin
              error_sum  <= '0;
              last_error <= '0;
              res_drive  <= '0;
              res_emerg  <= 1'b0;
              res_sat    <= 1'b0;
              res_paused <= 1'b1;
              state      <= ST_RES;
            end else if (dist_mm < stop_mm) begin
              error_sum  <= '0;
              res_drive  <= '0;
              res_emerg  <= 1'b1;
              res_sat    <= 1'b0;
              res_paused <= 1'b0;
              state      <= ST_RES;
            end else begin
              err_q      <= err_in;
              raw_q      <= raw_in;
              prev_sum   <= error_sum;
              error_sum  <= sum_sat;
              last_error <= err_in;
              keep_q     <= keep_eff;
              acc        <= '0;
              mcand      <= {{(ACC_W - SD_W){smoothed_diff[SD_W-1]}}, smoothed_diff};
              mplier     <= GAIN_W'(keep_eff);
              cnt        <= '0;
              state      <= ST_FKEEP;
            end
          end
        end
        ST_FKEEP: begin
          if (step_last) begin
            mcand  <= {{(ACC_W - RAW_W - 8){raw_q[RAW_W-1]}}, raw_q, 8'b0};
            mplier <= GAIN_W'(dhpc_pkg::KEEP_FULL - keep_q);
            cnt    <= '0;
            state  <= ST_FNEW;
          end
        end
        ST_FNEW: begin
          if (step_last) begin
            state <= ST_FDIV;
          end
        end
        ST_FDIV: begin
          smoothed_diff <= sd_new;
          acc           <= '0;
          mcand         <= {{(ACC_W - ERR_W - 8){err_q[ERR_W-1]}}, err_q, 8'b0};
          mplier        <= gain_prop;
          cnt           <= '0;
          state         <= ST_PROP;
        end
        ST_PROP: begin
          if (step_last) begin
            mcand  <= {{(ACC_W - SUM_W - 8){error_sum[SUM_W-1]}}, error_sum, 8'b0};
            mplier <= gain_integ;
            cnt    <= '0;
            state  <= ST_INTEG;
          end
        end
        ST_INTEG: begin
          if (step_last) begin
            mcand  <= {{(ACC_W - SD_W){smoothed_diff[SD_W-1]}}, smoothed_diff};
            mplier <= gain_deriv;
            cnt    <= '0;
            state  <= ST_DERIV;
          end
        end
        ST_DERIV: begin
          if (step_last) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          res_drive  <= drive_fin;
          res_emerg  <= 1'b0;
          res_sat    <= over;
          res_paused <= 1'b0;
          if (over) begin
            error_sum <= prev_sum;
          end
          state <= ST_RES;
        end
        ST_RES: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_drive  <= res_drive;
            out_emerg  <= res_emerg;
            out_sat    <= res_sat;
            out_paused <= res_paused;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_flags = {out_paused, out_sat, out_emerg};

  `DHPC_ASSERT_IMP(a_flags_excl, clk, rst, m_tvalid, $onehot0(out_flags))
  `DHPC_ASSERT_IMP(a_stop_zero, clk, rst, m_tvalid && (out_paused || out_emerg), out_drive == '0)
  `DHPC_ASSERT_NXT(a_accept_busy, clk, rst, s_tvalid && s_tready, !s_tready)
  `DHPC_ASSERT_NXT(a_stall_hold, clk, rst, (state == ST_RES) && m_tvalid && !m_tready, state == ST_RES)

endmodule

// ===== test/tb_distance_hold_pid_controller_unit.sv =====
`timescale 1ns / 1ps

module tb_distance_hold_pid_controller_unit;

  localparam int     DRIVE_SHIFT = dhpc_pkg::GAIN_FRAC_BITS_DEF + 8;
  localparam longint ITERM_LIMIT = 64'sh0010_0000_0000_0000;
  localparam longint SUM_MAX     = 64'sd2147483647;
  localparam longint SUM_MIN     = -64'sd2147483648;
  localparam int     MAX_CYCLES  = 3000000;
  localparam int     N_ROWS      = 25;
  localparam int     N_PHASES    = 10;

  typedef struct packed {
    logic signed [8:0] drive;
    logic              emergency;
    logic              saturated;
    logic              paused;
  } tick_result_t;

  typedef struct {
    logic [31:0] gain_prop;
    logic [31:0] gain_integ;
    logic [31:0] gain_deriv;
    logic [31:0] keep;
    logic [31:0] target;
    logic [31:0] stop;
    logic [31:0] limit;
  } reg_set_t;

  typedef struct {
    int setting;
    int dist_mm;
    bit run;
    bit typed_in;
    int drive;
    bit emg;
    bit sat;
    bit pau;
  } row_t;

  typedef enum {
    PH_DEFAULT, PH_MODERATE, PH_EXTREME, PH_ZERO, PH_WINDUP, PH_BIG_INTEG, PH_WILD
  } phase_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // distance_mm, running
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // drive, emergency, saturated, paused
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  dhpc_pkg::cfg_index_t cfg_index = dhpc_pkg::REG_GAIN_PROP;
  logic [31:0] cfg_data = '0;

  logic [31:0] cur_gain_prop  = dhpc_pkg::GAIN_PROP_RST;
  logic [31:0] cur_gain_integ = dhpc_pkg::GAIN_INTEG_RST;
  logic [31:0] cur_gain_deriv = dhpc_pkg::GAIN_DERIV_RST;
  logic [8:0]  cur_keep       = dhpc_pkg::FILTER_KEEP_RST;
  logic [12:0] cur_target     = 13'(dhpc_pkg::TARGET_MM_RST);
  logic [12:0] cur_stop       = 13'(dhpc_pkg::STOP_MM_RST);
  logic [7:0]  cur_limit      = dhpc_pkg::DRIVE_LIMIT_RST;

  int prev_err  = 0;
  int err_sum   = 0;
  int diff_filt = 0;

  tick_result_t awaited_outputs[$];
  tick_result_t head;
  int           error_count = 0;
  int           cycles = 0;
  int           stall_left = 0;
  bit           steady = 1'b0;

  row_t directed_rows [N_ROWS] = '{
    '{-1,    0, 0, 1,    0, 0, 0, 1},
    '{-1, 8191, 0, 1,    0, 0, 0, 1},
    '{-1,    0, 1, 1,    0, 1, 0, 0},
    '{-1,   29, 1, 1,    0, 1, 0, 0},
    '{-1,  150, 1, 1,    0, 0, 0, 0},
    '{-1,   30, 1, 0,    0, 0, 0, 0},
    '{-1, 8191, 1, 0,    0, 0, 0, 0},
    '{ 0, 8191, 1, 1,  255, 0, 1, 0},
    '{-1,    0, 1, 0,    0, 0, 0, 0},
    '{-1,    0, 0, 1,    0, 0, 0, 1},
    '{ 1, 4096, 1, 1,    0, 0, 0, 0},
    '{-1, 4097, 1, 1,    0, 0, 1, 0},
    '{-1, 4095, 1, 1,    0, 0, 1, 0},
    '{-1,    0, 1, 1,    0, 0, 1, 0},
    '{ 2, 4196, 1, 1,  100, 0, 0, 0},
    '{-1, 3996, 1, 1, -100, 0, 0, 0},
    '{-1,  999, 1, 1,    0, 1, 0, 0},
    '{-1, 1000, 1, 1, -255, 0, 1, 0},
    '{-1, 4351, 1, 1,  255, 0, 0, 0},
    '{-1, 4352, 1, 1,  255, 0, 1, 0},
    '{ 3, 4097, 1, 1,    0, 0, 0, 0},
    '{-1, 4095, 1, 1,    0, 0, 0, 0},
    '{-1, 4099, 1, 1,    1, 0, 0, 0},
    '{-1, 4093, 1, 1,   -1, 0, 0, 0},
    '{-1, 4496, 1, 1,  200, 0, 0, 0}
  };

  reg_set_t directed_sets [4] = '{
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1FF, 0, 0, 255},
    '{32'h0100_0000, 0, 0, 0, 4096, 0, 0},
    '{32'h0100_0000, 0, 0, 256, 4096, 1000, 255},
    '{32'h0080_0000, 0, 0, 300, 4096, 0, 200}
  };

  phase_kind_t phase_plan [N_PHASES] = '{
    PH_DEFAULT, PH_MODERATE, PH_EXTREME, PH_MODERATE, PH_ZERO,
    PH_WINDUP, PH_BIG_INTEG, PH_MODERATE, PH_WILD, PH_MODERATE
  };

  distance_hold_pid_controller_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 150);
    return $urandom_range(1, 4);
  endfunction

  function automatic tick_result_t pid_step(input logic [12:0] dist_mm, input logic run);
    tick_result_t res;
    longint err, raw, keep, total, prev_total, iterm, acc, n, lim, d;
    res = '0;
    d = 0;
    if (!run) begin
      err_sum = 0;
      prev_err = 0;
      res.paused = 1'b1;
    end else if (dist_mm < cur_stop) begin
      err_sum = 0;
      res.emergency = 1'b1;
    end else begin
      err = longint'(dist_mm) - longint'(cur_target);
      prev_total = err_sum;
      keep = (cur_keep > dhpc_pkg::KEEP_FULL) ? longint'(dhpc_pkg::KEEP_FULL)
                                              : longint'(cur_keep);
      raw = err - prev_err;
      total = prev_total + err;
      if (total > SUM_MAX) total = SUM_MAX;
      if (total < SUM_MIN) total = SUM_MIN;
      err_sum = int'(total);
      diff_filt = int'((keep * diff_filt + (256 - keep) * (raw * 256)) / 256);
      iterm = longint'(cur_gain_integ) * err_sum;
      if (iterm > ITERM_LIMIT) iterm = ITERM_LIMIT;
      if (iterm < -ITERM_LIMIT) iterm = -ITERM_LIMIT;
      acc = longint'(cur_gain_prop) * err + iterm;
      n = acc * 256 + longint'(cur_gain_deriv) * longint'(diff_filt);
      lim = longint'(cur_limit) << DRIVE_SHIFT;
      if (n > lim) begin
        d = longint'(cur_limit);
        res.saturated = 1'b1;
      end else if (n < -lim) begin
        d = -longint'(cur_limit);
        res.saturated = 1'b1;
      end else if (n >= 0) begin
        d = n >>> DRIVE_SHIFT;
      end else begin
        d = -((-n) >>> DRIVE_SHIFT);
      end
      if (res.saturated) err_sum = int'(prev_total);
      prev_err = int'(err);
    end
    res.drive = d[8:0];
    return res;
  endfunction

  function automatic logic [12:0] pick_distance();
    int v;
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) v = int'(cur_target) + int'($urandom_range(0, 600)) - 300;
    else if (r == 5) v = int'(cur_stop) + int'($urandom_range(0, 6)) - 3;
    else if (r == 6) v = $urandom_range(0, 1) ? 8191 : 0;
    else v = $urandom_range(0, 8191);
    if (v < 0) v = 0;
    if (v > 8191) v = 8191;
    return v[12:0];
  endfunction

  function automatic reg_set_t phase_settings(input phase_kind_t kind);
    reg_set_t s;
    case (kind)
      PH_DEFAULT: begin
        s = '{dhpc_pkg::GAIN_PROP_RST, dhpc_pkg::GAIN_INTEG_RST, dhpc_pkg::GAIN_DERIV_RST,
              32'(dhpc_pkg::FILTER_KEEP_RST), dhpc_pkg::TARGET_MM_RST,
              dhpc_pkg::STOP_MM_RST, 32'(dhpc_pkg::DRIVE_LIMIT_RST)};
      end
      PH_EXTREME: s = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1FF, 8191, 0, 255};
      PH_ZERO: s = '{0, 0, 0, 0, 0, 8191, 0};
      PH_WINDUP: s = '{0, 0, 0, $urandom_range(0, 511), 0, 0, 255};
      PH_BIG_INTEG: s = '{0, 32'hFFFF_FFFF, 0, $urandom_range(0, 511), 0, 0, 255};
      PH_WILD: s = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      default: begin
        s.gain_prop  = $urandom_range(0, 1 << 21);
        s.gain_integ = $urandom_range(0, 1 << 15);
        s.gain_deriv = $urandom_range(0, 1 << 23);
        s.keep       = $urandom_range(0, 300);
        s.target     = $urandom_range(200, 8000);
        s.stop       = $urandom_range(0, s.target);
        s.limit      = $urandom_range(0, 255);
      end
    endcase
    return s;
  endfunction

  task automatic write_reg(input dhpc_pkg::cfg_index_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      dhpc_pkg::REG_GAIN_PROP:   cur_gain_prop  = val;
      dhpc_pkg::REG_GAIN_INTEG:  cur_gain_integ = val;
      dhpc_pkg::REG_GAIN_DERIV:  cur_gain_deriv = val;
      dhpc_pkg::REG_FILTER_KEEP: cur_keep       = val[8:0];
      dhpc_pkg::REG_TARGET_MM:   cur_target     = val[12:0];
      dhpc_pkg::REG_STOP_MM:     cur_stop       = val[12:0];
      dhpc_pkg::REG_DRIVE_LIMIT: cur_limit      = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input reg_set_t s);
    write_reg(dhpc_pkg::REG_GAIN_PROP, s.gain_prop);
    write_reg(dhpc_pkg::REG_GAIN_INTEG, s.gain_integ);
    write_reg(dhpc_pkg::REG_GAIN_DERIV, s.gain_deriv);
    write_reg(dhpc_pkg::REG_FILTER_KEEP, s.keep);
    write_reg(dhpc_pkg::REG_TARGET_MM, s.target);
    write_reg(dhpc_pkg::REG_STOP_MM, s.stop);
    write_reg(dhpc_pkg::REG_DRIVE_LIMIT, s.limit);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (awaited_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_tick(input logic [12:0] dist_mm, input logic run, input bit typed_in,
                           input tick_result_t typed_res);
    int gap;
    tick_result_t pred;
    gap = (!steady && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {2'b00, run, dist_mm};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pred = pid_step(dist_mm, run);
    awaited_outputs.push_back(typed_in ? typed_res : pred);
  endtask

  // result beat check and receiver stalls
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_outputs.size() == 0) begin
        $error("result beat with no expectation pending: %h", m_tdata);
        error_count++;
      end else begin
        head = awaited_outputs.pop_front();
        if (m_tdata[8:0] !== head.drive) begin
          $error("drive: expected %0d, got %0d", head.drive, $signed(m_tdata[8:0]));
          error_count++;
        end
        if (m_tdata[9] !== head.emergency) begin
          $error("emergency: expected %0d, got %0d", head.emergency, m_tdata[9]);
          error_count++;
        end
        if (m_tdata[10] !== head.saturated) begin
          $error("saturated: expected %0d, got %0d", head.saturated, m_tdata[10]);
          error_count++;
        end
        if (m_tdata[11] !== head.paused) begin
          $error("paused: expected %0d, got %0d", head.paused, m_tdata[11]);
          error_count++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 15) == 0) begin
      stall_left = idle_len();
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= MAX_CYCLES) begin
      $display("distance_hold_pid_controller_unit regression: fail");
      $finish;
    end
  end

  initial begin
    tick_result_t fr;
    logic [12:0]  dist_mm;
    logic         run;
    int           n_items;
    phase_kind_t  kind;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].setting >= 0) begin
        wait_idle();
        load_settings(directed_sets[directed_rows[i].setting]);
      end
      fr.drive     = 9'(directed_rows[i].drive);
      fr.emergency = directed_rows[i].emg;
      fr.saturated = directed_rows[i].sat;
      fr.paused    = directed_rows[i].pau;
      send_tick(13'(directed_rows[i].dist_mm), directed_rows[i].run,
                directed_rows[i].typed_in, fr);
    end

    foreach (phase_plan[p]) begin
      kind = phase_plan[p];
      wait_idle();
      steady = ($urandom_range(0, 3) == 0);
      load_settings(phase_settings(kind));
      n_items = (kind == PH_WINDUP) ? 300 : 150;
      for (int i = 0; i < n_items; i++) begin
        // keep the error large so the integral grows and the big integral gain saturates the drive
        if (kind == PH_WINDUP || (kind == PH_BIG_INTEG && i < 20)) begin
          dist_mm = 13'($urandom_range(6000, 8191));
          run     = 1'b1;
        end else begin
          dist_mm = pick_distance();
          run     = ($urandom_range(0, 15) != 0);
        end
        send_tick(dist_mm, run, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (awaited_outputs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0 && awaited_outputs.size() == 0) begin
      $display("distance_hold_pid_controller_unit regression: pass");
    end else begin
      $display("distance_hold_pid_controller_unit regression: fail");
    end
    $finish;
  end

endmodule
